/* rtl/gn1d_pkg.sv */
// ----------------------------------------------------------------------------
// gn1d_pkg: shared definitions for the 1-D gradient noise unit
// Constants of the MT19937 seeding and tempering, the sequencer state type and
// the operand / product widths of the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package gn1d_pkg;

   // Field widths
   localparam int POS_W          = 32;
   localparam int NOISE_W        = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // Shared multiplier: signed operands, full product
   localparam int MUL_W          = 34;
   localparam int PROD_W         = 2 * MUL_W;

   // MT19937 constants
   localparam logic [31:0] MT_INIT_MUL = 32'h6C07_8965;
   localparam logic [31:0] MT_MATRIX   = 32'h9908_B0DF;
   localparam int          MT_SHIFT    = 397;
   localparam int          MT_LAST     = MT_SHIFT + 1;
   localparam int          CNT_W       = $clog2(MT_LAST + 1);

   // Output saturation limits, applied to a 19-bit intermediate
   localparam int          RES_W       = MUL_W + 1 - 16;
   localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32767);
   localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(32768);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_TWIST,
      ST_DOT0,
      ST_DOT1,
      ST_SQUARE,
      ST_SMOOTH,
      ST_TCAP,
      ST_MIX,
      ST_FINAL
   } gn1d_state_type;

   // MT19937 output tempering
   function automatic logic [31:0] mt_temper(input logic [31:0] y_raw);
      logic [31:0] y;
      y = y_raw;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // One twist step: upper bit of one word, lower bits of the next
   function automatic logic [31:0] mt_twist(input logic [31:0] far_word,
                                            input logic [31:0] y);
      logic [31:0] mag;
      mag = y[0] ? MT_MATRIX : 32'h0;
      return far_word ^ (y >> 1) ^ mag;
   endfunction

endpackage

`default_nettype wire

/* rtl/gradient_noise_1d_unit.sv */
// ----------------------------------------------------------------------------
// gradient_noise_1d_unit: one-dimensional gradient noise generator
// Takes a signed fixed-point position and returns Q1.15 gradient noise, with
// gradients drawn from an MT19937 generator seeded by the cell index.
// ----------------------------------------------------------------------------
// One item is worked at a time. After a beat is accepted on req_, the cell
// index floor(position) seeds MT19937; the seed recurrence runs one step per
// cycle through the single shared multiplier. Then twist/temper, two dot
// products, smoothstep, blend and saturation bring the result into the rsp_
// output register; req_ready returns in the same cycle, and a new position is
// only taken once the last one is through.
// A result left waiting on rsp_ does not block the next item; the unit only
// stalls in its last step if the previous result has still not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_1d_unit
   import gn1d_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [POS_W-1:0]    req_position,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [NOISE_W-1:0]       rsp_noise_value
);

   localparam logic [MUL_W-1:0] ONE   = MUL_W'(1) << FRAC_BITS;
   localparam logic [MUL_W-1:0] THREE = MUL_W'(3) << FRAC_BITS;

   gn1d_state_type state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [NOISE_W-1:0]   rsp_noise_value_ff;

   logic [31:0]                 seed_ff;
   logic [FRAC_BITS-1:0]        f_ff;
   logic [31:0]                 mt1_ff;
   logic [30:0]                 mt2_ff;
   logic [31:0]                 mt397_ff;
   logic signed [31:0]          g0_ff, g1_ff;
   logic signed [MUL_W-1:0]     dot0_ff, dot1_ff, diff_ff;
   logic [FRAC_BITS:0]          t_ff;

   logic                        mul_en;
   logic signed [MUL_W-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_sh;
   logic signed [MUL_W-1:0]     prod_q;

   logic [31:0]                 mt_cur, mt_scr;
   logic [31:0]                 v0, v1;
   logic signed [MUL_W:0]       mix;
   logic signed [RES_W-1:0]     res;
   logic signed [NOISE_W-1:0]   res_sat;
   logic                        req_beat, final_load;

   assign req_ready       = (state_ff == ST_IDLE);
   assign req_beat        = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;
   assign final_load      = (state_ff == ST_FINAL) && (!rsp_valid_ff || rsp_ready);

   // product scaled back by the fraction width (floor)
   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign prod_q  = prod_sh[MUL_W-1:0];

   // current MT word: seed first, then last product plus index
   assign mt_cur = (cnt_ff == '0) ? seed_ff : (prod_ff[31:0] + 32'(cnt_ff));
   assign mt_scr = mt_cur ^ (mt_cur >> 30);

   // first two MT outputs before tempering
   assign v0 = mt_twist(mt397_ff, {seed_ff[31], mt1_ff[30:0]});
   assign v1 = mt_twist(mt_cur, {mt1_ff[31], mt2_ff});

   // blend and saturation
   assign mix = (MUL_W + 1)'(dot0_ff) + (MUL_W + 1)'(prod_q);
   assign res = RES_W'(mix >>> 16);

   always_comb begin
      if (res > RES_MAX) begin
         res_sat = NOISE_W'(RES_MAX);
      end else if (res < RES_MIN) begin
         res_sat = NOISE_W'(RES_MIN);
      end else begin
         res_sat = res[NOISE_W-1:0];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         ST_SEED: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(mt_scr);
            mul_b  = MUL_W'(MT_INIT_MUL);
         end
         ST_DOT0: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(g0_ff);
            mul_b  = MUL_W'(f_ff);
         end
         ST_DOT1: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(g1_ff);
            mul_b  = MUL_W'(f_ff) - ONE;
         end
         ST_SQUARE: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(f_ff);
            mul_b  = MUL_W'(f_ff);
         end
         ST_SMOOTH: begin
            mul_en = 1'b1;
            mul_a  = prod_q;
            mul_b  = THREE - (MUL_W'(f_ff) << 1);
         end
         ST_MIX: begin
            mul_en = 1'b1;
            mul_a  = diff_ff;
            mul_b  = MUL_W'(t_ff);
         end
         ST_IDLE, ST_TWIST, ST_TCAP, ST_FINAL: begin
            mul_en = 1'b0;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   gn1d_mul u_mul (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_beat) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MT_SHIFT)) begin
               state_in = ST_TWIST;
            end
         end
         ST_TWIST:  state_in = ST_DOT0;
         ST_DOT0:   state_in = ST_DOT1;
         ST_DOT1:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SMOOTH;
         ST_SMOOTH: state_in = ST_TCAP;
         ST_TCAP:   state_in = ST_MIX;
         ST_MIX:    state_in = ST_FINAL;
         ST_FINAL: begin
            if (final_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat valid
   always_comb begin
      if (final_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         seed_ff <= {{FRAC_BITS{req_position[POS_W-1]}}, req_position[POS_W-1:FRAC_BITS]};
         f_ff    <= req_position[FRAC_BITS-1:0];
      end
      if (state_ff == ST_SEED) begin
         if (cnt_ff == CNT_W'(1)) begin
            mt1_ff <= mt_cur;
         end
         if (cnt_ff == CNT_W'(2)) begin
            mt2_ff <= mt_cur[30:0];
         end
         if (cnt_ff == CNT_W'(MT_SHIFT)) begin
            mt397_ff <= mt_cur;
         end
      end
      if (state_ff == ST_TWIST) begin
         g0_ff <= mt_temper(v0) ^ 32'h8000_0000;
         g1_ff <= mt_temper(v1) ^ 32'h8000_0000;
      end
      if (state_ff == ST_DOT1) begin
         dot0_ff <= prod_q;
      end
      if (state_ff == ST_SQUARE) begin
         dot1_ff <= prod_q;
      end
      if (state_ff == ST_TCAP) begin
         t_ff    <= prod_q[FRAC_BITS:0];
         diff_ff <= dot1_ff - dot0_ff;
      end
      if (final_load) begin
         rsp_noise_value_ff <= res_sat;
      end
   end

   // a new result only appears out of the final step
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINAL))
      else $error("result beat raised outside the final step");

   // an accepted beat starts the seed recurrence at index zero
   a_start_seed: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_SEED) && (cnt_ff == '0))
      else $error("accepted beat did not start seeding");

   // the twist step sees the last recurrence index
   a_twist_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TWIST) |-> (cnt_ff == CNT_W'(MT_LAST)))
      else $error("twist reached with wrong seed index");

   // seeding leaves only toward the twist step
   a_seed_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED) |=> (state_ff == ST_SEED) || (state_ff == ST_TWIST))
      else $error("seeding left to an unexpected state");

endmodule

`default_nettype wire

/* rtl/gn1d_mul.sv */
// ----------------------------------------------------------------------------
// gn1d_mul: shared signed multiplier with registered product
// Every multiply of the unit (seed recurrence, dot products, smoothstep and
// blend) runs through this one multiplier, one product per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gn1d_mul
   import gn1d_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     mul_en,
   input  wire logic signed [MUL_W-1:0]  mul_a,
   input  wire logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]      prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // full signed product
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 1-D gradient noise unit
// Drives positions on req_ and checks every rsp_ beat against a bit-exact
// predictor of the seeded-generator / smoothstep noise, or the table value
// for typed rows. A short directed table runs first, then a random mix weighted
// toward cell and fraction edges, with random idle bursts on both channels.
// ----------------------------------------------------------------------------

module tb_top
   import gn1d_pkg::*;
();

   typedef logic signed [POS_W-1:0]   position_type;
   typedef logic signed [NOISE_W-1:0] noise_type;

   localparam int FRAC_W       = 16;
   localparam int RANDOM_ITEMS = 1440;
   localparam int QUIET_ITEMS  = 150;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 450;

   // Generator seeding / twist constants
   localparam logic [31:0] SEED_MUL    = 32'd1812433253;
   localparam logic [31:0] TWIST_XOR   = 32'h9908_B0DF;
   localparam int          FAR_OFFSET  = 397;

   // One row of the directed table
   typedef struct {
      position_type pos;
      bit           typed;
      noise_type    want;
   } drive_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   position_type req_position;
   logic         rsp_valid;
   logic         rsp_ready;
   noise_type    rsp_noise_value;

   noise_type    noise_expected [$];
   int           mismatch_count = 0;
   bit           quiet = 1'b0;

   // Whole-cell positions have a zero fraction, so the noise is zero there
   drive_row_type directed_rows [22] = '{
      '{32'h0000_0000, 1'b1, 16'sd0},
      '{32'h0001_0000, 1'b1, 16'sd0},
      '{32'hFFFF_0000, 1'b1, 16'sd0},
      '{32'h7FFF_0000, 1'b1, 16'sd0},
      '{32'h8000_0000, 1'b1, 16'sd0},
      '{32'h7FFF_FFFF, 1'b0, 16'sd0},
      '{32'h8000_0001, 1'b0, 16'sd0},
      '{32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{32'h0000_0001, 1'b0, 16'sd0},
      '{32'h0000_FFFF, 1'b0, 16'sd0},
      '{32'h0000_8000, 1'b0, 16'sd0},
      '{32'hFFFF_8000, 1'b0, 16'sd0},
      '{32'h0001_FFFF, 1'b0, 16'sd0},
      '{32'h7FFF_8000, 1'b0, 16'sd0},
      '{32'h8000_8000, 1'b0, 16'sd0},
      '{32'h5555_5555, 1'b0, 16'sd0},
      '{32'hAAAA_AAAA, 1'b0, 16'sd0},
      '{32'h1234_5678, 1'b0, 16'sd0},
      '{32'hFEDC_BA98, 1'b0, 16'sd0},
      '{32'h0001_7FFF, 1'b0, 16'sd0},
      '{32'h0000_4000, 1'b0, 16'sd0},
      '{32'h0000_C000, 1'b0, 16'sd0}
   };

   gradient_noise_1d_unit #(
      .FRAC_BITS (FRAC_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the unit hangs
   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Twist one word from the seeded table, then temper it into a draw
   function automatic logic [31:0] tempered_draw(input logic [31:0] upper_src,
                                                 input logic [31:0] lower_src,
                                                 input logic [31:0] far_word);
      logic [31:0] y;
      logic [31:0] v;
      y = {upper_src[31], lower_src[30:0]};
      v = far_word ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & 32'h9D2C_5680);
      v = v ^ ((v << 15) & 32'hEFC6_0000);
      v = v ^ (v >> 18);
      return v;
   endfunction

   // Bit-exact noise for one position
   function automatic noise_type predict_noise(input position_type pos);
      logic [31:0] word;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w_far0;
      logic [31:0] w_far1;
      logic [31:0] u0;
      logic [31:0] u1;
      longint      sp;
      longint      unit_one;
      longint      f;
      longint      g0;
      longint      g1;
      longint      dot0;
      longint      dot1;
      longint      t;
      longint      mix;
      longint      res;
      sp       = longint'(pos);
      unit_one = 64'sd1 <<< FRAC_W;
      f        = sp & (unit_one - 1);
      // floor(position) seeds the generator
      word = 32'(sp >>> FRAC_W);
      w0 = word;
      w1 = '0;
      w2 = '0;
      w_far0 = '0;
      w_far1 = '0;
      for (int k = 1; k <= FAR_OFFSET + 1; k++) begin
         word = (word ^ (word >> 30)) * SEED_MUL + 32'(k);
         if (k == 1) w1 = word;
         if (k == 2) w2 = word;
         if (k == FAR_OFFSET) w_far0 = word;
         if (k == FAR_OFFSET + 1) w_far1 = word;
      end
      u0 = tempered_draw(w0, w1, w_far0);
      u1 = tempered_draw(w1, w2, w_far1);
      // gradients as signed Q1.31
      g0 = longint'({32'd0, u0}) - 64'sd2147483648;
      g1 = longint'({32'd0, u1}) - 64'sd2147483648;
      dot0 = (g0 * f) >>> FRAC_W;
      dot1 = (g1 * (f - unit_one)) >>> FRAC_W;
      // smoothstep weight
      t = (f * f) >>> FRAC_W;
      t = (t * (3 * unit_one - 2 * f)) >>> FRAC_W;
      mix = dot0 + (((dot1 - dot0) * t) >>> FRAC_W);
      res = mix >>> 16;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return noise_type'(res[15:0]);
   endfunction

   // Present one position and hold it until the beat is taken
   task automatic send_position(input position_type pos, input bit typed,
                                input noise_type want);
      req_valid    <= 1'b1;
      req_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed)
         noise_expected.push_back(want);
      else
         noise_expected.push_back(predict_noise(pos));
   endtask

   // Random idle burst on the request side
   task automatic sender_gap();
      int n;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         n = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending until every outstanding result has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (noise_expected.size() != 0);
   endtask

   // Result side: random stall bursts between ready stretches
   initial begin : result_sink
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 9);
            repeat (n) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         n = $urandom_range(1, 40);
         repeat (n) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      noise_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (noise_expected.size() == 0) begin
            flag_mismatch($sformatf("unexpected result %0d", rsp_noise_value));
         end else begin
            want = noise_expected.pop_front();
            if (rsp_noise_value !== want)
               flag_mismatch($sformatf("noise_value got %0d want %0d",
                                       rsp_noise_value, want));
         end
      end
   end

   initial begin : stimulus
      logic [15:0]  cell_bits;
      logic [15:0]  frac;
      position_type pos;
      int           waited;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_position <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (directed_rows[r]) begin
         sender_gap();
         send_position(directed_rows[r].pos, directed_rows[r].typed, directed_rows[r].want);
      end
      hold_until_drained();

      // Random mix: full range, cells near zero, fraction edges, extreme cells
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) hold_until_drained();
         if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         cell_bits = 16'($urandom);
         frac = 16'($urandom);
         case ($urandom_range(0, 4))
            0: begin
               cell_bits = 16'($urandom_range(0, 8)) - 16'd4;
            end
            1: begin
               case ($urandom_range(0, 5))
                  0: frac = 16'h0000;
                  1: frac = 16'h0001;
                  2: frac = 16'h7FFF;
                  3: frac = 16'h8000;
                  4: frac = 16'hFFFE;
                  default: frac = 16'hFFFF;
               endcase
            end
            2: begin
               if ($urandom_range(0, 1) == 0)
                  cell_bits = 16'h7FFF - 16'($urandom_range(0, 2));
               else
                  cell_bits = 16'h8000 + 16'($urandom_range(0, 2));
            end
            default: ;
         endcase
         pos = {cell_bits, frac};
         sender_gap();
         send_position(pos, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain, then give any stray beat time to show up
      waited = 0;
      while (noise_expected.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (noise_expected.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", noise_expected.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
